### hw/rtl/mltd_pkg.sv
// Package with the shared types and constants of the magic, length and type deframer.
`default_nettype none

package mltd_pkg;

  localparam logic [1:0] KIND_DATA      = 2'd0;
  localparam logic [1:0] KIND_EMPTY     = 2'd1;
  localparam logic [1:0] KIND_BAD_MAGIC = 2'd2;

  localparam logic [2:0] MAGIC_LEN  = 3'd6;
  localparam logic [2:0] MAGIC_LAST = 3'd5;
  localparam logic [2:0] WORD_LEN   = 3'd4;
  localparam logic [2:0] WORD_LAST  = 3'd3;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  data;
    logic [31:0] msg_type;
    logic [31:0] msg_len;
    logic        last;
  } res_t;

  function automatic logic [7:0] magic_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h69;
      3'd1:    ch = 8'h33;
      3'd2:    ch = 8'h2D;
      3'd3:    ch = 8'h69;
      3'd4:    ch = 8'h70;
      3'd5:    ch = 8'h63;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/magic_length_type_deframer_unit.sv
// Top level of the deframer that checks the magic, gathers length and type, and passes the payload.
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------------------
//  in      | input     | in_valid/stall   | in_stream_byte
//  out     | output    | out_valid/stall  | out_result_kind, out_payload_byte,
//          |           |                  | out_message_type, out_message_length,
//          |           |                  | out_last_of_message
//
// One byte is accepted per cycle while in_stall is low; its result, if any, is registered.
// The parse state updates in the cycle of the transaction, and so does the result register if it is free.
// A skid register behind the result register lets one more byte in while out is stalled.
// The input stalls only while the skid register holds a result.
// Reset is synchronous and returns the parser to the magic hunt with both registers empty.
`default_nettype none

module magic_length_type_deframer_unit
  import mltd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_stream_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_result_kind,
  output logic [7:0]       out_payload_byte,
  output logic [31:0]      out_message_type,
  output logic [31:0]      out_message_length,
  output logic             out_last_of_message
);

  localparam logic [1:0] PH_MAGIC   = 2'd0;
  localparam logic [1:0] PH_LENGTH  = 2'd1;
  localparam logic [1:0] PH_TYPE    = 2'd2;
  localparam logic [1:0] PH_PAYLOAD = 2'd3;

  logic [1:0]  phase_r, phase_nxt;
  logic [2:0]  idx_r, idx_nxt;
  logic [31:0] len_r, len_nxt;
  logic [31:0] typ_r, typ_nxt;
  logic [31:0] rem_r, rem_nxt;

  logic        res_vld;
  res_t        res;
  logic        pay_last;

  logic        out_vld_r;
  res_t        out_r;
  logic        skid_vld_r;
  res_t        skid_r;

  logic        in_acc;
  logic        out_take;

  assign in_stall = skid_vld_r;
  assign in_acc   = in_valid & ~skid_vld_r;
  assign out_take = out_vld_r & ~out_stall;
  assign pay_last = (rem_r <= 32'd1);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    len_nxt   = len_r;
    typ_nxt   = typ_r;
    rem_nxt   = rem_r;
    res_vld   = 1'b0;
    res       = '0;
    unique case (phase_r)
      PH_MAGIC: begin
        if (idx_r >= MAGIC_LEN || in_stream_byte != magic_char(idx_r)) begin
          idx_nxt  = '0;
          res_vld  = 1'b1;
          res.kind = KIND_BAD_MAGIC;
        end else if (idx_r == MAGIC_LAST) begin
          idx_nxt   = '0;
          len_nxt   = '0;
          typ_nxt   = '0;
          phase_nxt = PH_LENGTH;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_LENGTH: begin
        if (idx_r < WORD_LEN) begin
          len_nxt = len_r | (32'(in_stream_byte) << {idx_r[1:0], 3'b000});
        end
        if (idx_r >= WORD_LAST) begin
          idx_nxt   = '0;
          phase_nxt = PH_TYPE;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
      PH_TYPE: begin
        if (idx_r < WORD_LEN) begin
          typ_nxt = typ_r | (32'(in_stream_byte) << {idx_r[1:0], 3'b000});
        end
        if (idx_r < WORD_LAST) begin
          idx_nxt = idx_r + 3'd1;
        end else begin
          idx_nxt = '0;
          if (len_r == 32'd0) begin
            phase_nxt    = PH_MAGIC;
            rem_nxt      = '0;
            res_vld      = 1'b1;
            res.kind     = KIND_EMPTY;
            res.msg_type = typ_nxt;
            res.last     = 1'b1;
          end else begin
            rem_nxt   = len_r;
            phase_nxt = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        res_vld      = 1'b1;
        res.kind     = KIND_DATA;
        res.data     = in_stream_byte;
        res.msg_type = typ_r;
        res.msg_len  = len_r;
        res.last     = pay_last;
        if (pay_last) begin
          rem_nxt   = '0;
          idx_nxt   = '0;
          phase_nxt = PH_MAGIC;
        end else begin
          rem_nxt = rem_r - 32'd1;
        end
      end
      default: begin
        phase_nxt = PH_MAGIC;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_MAGIC;
      idx_r   <= '0;
      len_r   <= '0;
      typ_r   <= '0;
      rem_r   <= '0;
    end else if (in_acc) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      len_r   <= len_nxt;
      typ_r   <= typ_nxt;
      rem_r   <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_take) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end
    end else if (in_acc && res_vld) begin
      if (!out_vld_r || out_take) begin
        out_vld_r <= 1'b1;
      end else begin
        skid_vld_r <= 1'b1;
      end
    end else if (out_take) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_take) begin
        out_r <= skid_r;
      end
    end else if (in_acc && res_vld) begin
      if (!out_vld_r || out_take) begin
        out_r <= res;
      end else begin
        skid_r <= res;
      end
    end
  end

  assign out_valid           = out_vld_r;
  assign out_result_kind     = out_r.kind;
  assign out_payload_byte    = out_r.data;
  assign out_message_type    = out_r.msg_type;
  assign out_message_length  = out_r.msg_len;
  assign out_last_of_message = out_r.last;

endmodule

`default_nettype wire

### hw/rtl/mltd_checker.sv
// Port checker for the deframer and the bind that attaches it to the top level.
`default_nettype none

module mltd_checker
  import mltd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  out_result_kind,
  input wire logic [7:0]  out_payload_byte,
  input wire logic [31:0] out_message_type,
  input wire logic [31:0] out_message_length,
  input wire logic        out_last_of_message
);

  // An error result carries no frame information.
  a_bad_magic_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_BAD_MAGIC) |->
      (out_payload_byte == 8'd0 && out_message_type == 32'd0 &&
       out_message_length == 32'd0 && !out_last_of_message))
    else $error("bad magic result carries frame fields");

  // An empty message is a complete message of length zero.
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_EMPTY) |->
      (out_last_of_message && out_message_length == 32'd0 && out_payload_byte == 8'd0))
    else $error("empty message result is malformed");

  // Every byte of a one-byte payload ends its message.
  a_single_byte_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == KIND_DATA && out_message_length == 32'd1) |->
      out_last_of_message)
    else $error("one-byte payload not marked last");

  // The unused result kind never appears.
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_result_kind == KIND_DATA || out_result_kind == KIND_EMPTY ||
                   out_result_kind == KIND_BAD_MAGIC))
    else $error("illegal result kind");

  // A stalled result transaction holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_result_kind) && $stable(out_payload_byte) &&
       $stable(out_message_type) && $stable(out_message_length) &&
       $stable(out_last_of_message)))
    else $error("stalled result changed");

endmodule

bind magic_length_type_deframer_unit mltd_checker u_mltd_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_result_kind     (out_result_kind),
  .out_payload_byte    (out_payload_byte),
  .out_message_type    (out_message_type),
  .out_message_length  (out_message_length),
  .out_last_of_message (out_last_of_message)
);

`default_nettype wire
